// ----- hdl/mbrtu_pkg.sv -----
// Package with beat types, codes and the CRC-16 byte update for the Modbus RTU responder.
`timescale 1ns / 1ps

package mbrtu_pkg;

    localparam int unsigned MBRTU_MAX_QUANTITY = 125;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] DATA_HIGH_BYTE    = 8'h00;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_ID_LOW   = 2'd0;
    localparam logic [1:0] REG_ID_HIGH  = 2'd1;
    localparam logic [1:0] REG_REPLY_ID = 2'd2;

    localparam logic [7:0] ID_LOW_RESET   = 8'd1;
    localparam logic [7:0] ID_HIGH_RESET  = 8'd3;
    localparam logic [7:0] REPLY_ID_RESET = 8'd1;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef enum logic [2:0] {
        RX_NONE     = 3'd0,
        RX_CRC_ERR  = 3'd1,
        RX_ACCEPTED = 3'd2,
        RX_IGNORED  = 3'd3,
        RX_QTY_ERR  = 3'd4
    } mbrtu_status_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       frame_start;
    } mbrtu_in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [2:0] rx_status;
    } mbrtu_out_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/modbus_rtu_read_holding_responder.sv -----
// Top level of the Modbus RTU read-holding-registers responder.
//
//  channel | ports                         | beat
//  --------+-------------------------------+-------------------------------------------
//  input   | s_valid s_ready s_data        | op, rx_byte, frame_start
//  result  | m_valid m_ready m_data        | tx_valid, tx_byte, tx_last, rx_status
//  config  | psel penable pwrite paddr ... | id_low @0x0, id_high @0x4, reply_id @0x8
//
// One beat in, one beat out; a beat is taken every cycle that s_ready is high, its
// result is in the output register in the next cycle. The CRC-16 update of one byte
// is an unrolled eight-step chain between the state registers. s_ready drops only
// while a held result is stalled by m_ready. Reset initialises all state but the out beat.
`timescale 1ns / 1ps

module modbus_rtu_read_holding_responder
    import mbrtu_pkg::*;
#(
    parameter int unsigned MAX_QUANTITY = MBRTU_MAX_QUANTITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mbrtu_in_t         s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mbrtu_out_t        m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned QTY_W = $clog2(MAX_QUANTITY + 1);
    localparam int unsigned POS_W = $clog2(2 * MAX_QUANTITY + 6);

    logic [7:0] id_low_reg, id_high_reg, reply_id_reg;

    logic [5:0][7:0]  req_bytes_reg, req_bytes_next;
    logic [2:0]       req_count_reg, req_count_next;
    logic [15:0]      req_crc_reg, req_crc_next;
    logic             crc_low_match_reg, crc_low_match_next;
    logic             pending_reg, pending_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [QTY_W-1:0] quantity_reg, quantity_next;
    logic [7:0]       start_low_reg, start_low_next;
    logic [15:0]      reply_crc_reg, reply_crc_next;

    logic       out_valid_reg;
    mbrtu_out_t out_reg, out_next;

    logic       accept;
    logic       cfg_write;
    logic [2:0] cnt;
    logic [15:0] qty;
    logic [POS_W-1:0] data_len;
    logic [POS_W-1:0] offset;
    logic [7:0] tx_val;

    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_ID_LOW:   prdata = {24'h0, id_low_reg};
            REG_ID_HIGH:  prdata = {24'h0, id_high_reg};
            REG_REPLY_ID: prdata = {24'h0, reply_id_reg};
            default:      prdata = 32'h0;
        endcase
    end

    always_comb begin
        req_bytes_next     = req_bytes_reg;
        req_count_next     = req_count_reg;
        req_crc_next       = req_crc_reg;
        crc_low_match_next = crc_low_match_reg;
        pending_next       = pending_reg;
        position_next      = position_reg;
        quantity_next      = quantity_reg;
        start_low_next     = start_low_reg;
        reply_crc_next     = reply_crc_reg;
        out_next           = '0;
        cnt                = req_count_reg;
        qty                = {req_bytes_reg[4], req_bytes_reg[5]};
        data_len           = POS_W'(3) + (POS_W'(quantity_reg) << 1);
        offset             = position_reg - POS_W'(3);
        tx_val             = 8'h00;

        if (s_data.op == OP_RX) begin
            if (s_data.frame_start) begin
                pending_next       = 1'b0;
                cnt                = 3'd0;
                req_crc_next       = CRC_INIT;
                crc_low_match_next = 1'b0;
                req_bytes_next     = '0;
            end
            if (s_data.frame_start || req_count_reg != 3'd0) begin
                if (cnt < 3'd6) begin
                    req_bytes_next[cnt] = s_data.rx_byte;
                    req_crc_next        = crc_add(req_crc_next, s_data.rx_byte);
                    req_count_next      = cnt + 3'd1;
                end else if (cnt == 3'd6) begin
                    crc_low_match_next = (s_data.rx_byte == req_crc_reg[7:0]);
                    req_count_next     = 3'd7;
                end else begin
                    req_count_next = 3'd0;
                    if (!crc_low_match_reg || s_data.rx_byte != req_crc_reg[15:8]) begin
                        out_next.rx_status = RX_CRC_ERR;
                    end else if (req_bytes_reg[0] < id_low_reg
                              || req_bytes_reg[0] > id_high_reg
                              || req_bytes_reg[1] != FUNC_READ_HOLDING) begin
                        out_next.rx_status = RX_IGNORED;
                    end else if (qty > 16'(MAX_QUANTITY)) begin
                        out_next.rx_status = RX_QTY_ERR;
                    end else begin
                        out_next.rx_status = RX_ACCEPTED;
                        pending_next       = 1'b1;
                        position_next      = '0;
                        quantity_next      = QTY_W'(qty);
                        start_low_next     = req_bytes_reg[3];
                        reply_crc_next     = CRC_INIT;
                    end
                end
            end
        end else if (pending_reg) begin
            if (position_reg < data_len) begin
                if (position_reg == POS_W'(0)) begin
                    tx_val = reply_id_reg;
                end else if (position_reg == POS_W'(1)) begin
                    tx_val = FUNC_READ_HOLDING;
                end else if (position_reg == POS_W'(2)) begin
                    tx_val = 8'({quantity_reg, 1'b0});
                end else if (!offset[0]) begin
                    tx_val = DATA_HIGH_BYTE;
                end else begin
                    tx_val = start_low_reg + 8'(offset >> 1);
                end
                reply_crc_next = crc_add(reply_crc_reg, tx_val);
                position_next  = position_reg + POS_W'(1);
            end else if (position_reg == data_len) begin
                tx_val        = reply_crc_reg[7:0];
                position_next = position_reg + POS_W'(1);
            end else begin
                tx_val           = reply_crc_reg[15:8];
                out_next.tx_last = 1'b1;
                pending_next     = 1'b0;
                position_next    = '0;
            end
            out_next.tx_valid = 1'b1;
            out_next.tx_byte  = tx_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_low_reg        <= ID_LOW_RESET;
            id_high_reg       <= ID_HIGH_RESET;
            reply_id_reg      <= REPLY_ID_RESET;
            req_bytes_reg     <= '0;
            req_count_reg     <= 3'd0;
            req_crc_reg       <= CRC_INIT;
            crc_low_match_reg <= 1'b0;
            pending_reg       <= 1'b0;
            position_reg      <= '0;
            quantity_reg      <= '0;
            start_low_reg     <= 8'h00;
            reply_crc_reg     <= CRC_INIT;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr[3:2])
                    REG_ID_LOW:   id_low_reg   <= pwdata[7:0];
                    REG_ID_HIGH:  id_high_reg  <= pwdata[7:0];
                    REG_REPLY_ID: reply_id_reg <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (accept) begin
                req_bytes_reg     <= req_bytes_next;
                req_count_reg     <= req_count_next;
                req_crc_reg       <= req_crc_next;
                crc_low_match_reg <= crc_low_match_next;
                pending_reg       <= pending_next;
                position_reg      <= position_next;
                quantity_reg      <= quantity_next;
                start_low_reg     <= start_low_next;
                reply_crc_reg     <= reply_crc_next;
                out_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- hdl/mbrtu_checker.sv -----
// Port checker for the Modbus RTU responder and its bind to the top level.
`timescale 1ns / 1ps

module mbrtu_checker
    import mbrtu_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input mbrtu_out_t m_data
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    a_last_is_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tx_last |-> m_data.tx_valid)
        else $error("tx_last without tx_valid");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.tx_valid |-> m_data.tx_byte == 8'h00)
        else $error("tx_byte nonzero without tx_valid");

    a_status_on_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rx_status != RX_NONE |->
            !m_data.tx_valid && m_data.rx_status <= RX_QTY_ERR)
        else $error("bad rx_status on result beat");

endmodule

bind modbus_rtu_read_holding_responder mbrtu_checker u_mbrtu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
